// ----- rtl/ritp_pkg.sv -----
// ritp_pkg: shared types, operator codes and character constants for the
// regex infix-to-postfix converter; no dependencies
`default_nettype none

package ritp_pkg;

  // queue depths between the parts
  localparam int CMDQ_DEPTH = 2;
  localparam int RESQ_DEPTH = 2;

  // stacked operator codes, ordered by binding strength (lower binds tighter)
  localparam logic [1:0] OP_LPAREN = 2'd0;
  localparam logic [1:0] OP_STAR   = 2'd1;
  localparam logic [1:0] OP_CAT    = 2'd2;
  localparam logic [1:0] OP_ALT    = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_PAREN    = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  // input action codes
  localparam logic ACT_BYTE  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // ascii characters
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CAT    = 8'h26;
  localparam logic [7:0] CH_ALT    = 8'h7C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  typedef enum logic [2:0] {
    CMD_OPERAND,
    CMD_OPER,
    CMD_LPAREN,
    CMD_RPAREN,
    CMD_FLUSH
  } cmd_kind_t;

  // classified command from front to back
  typedef struct packed {
    cmd_kind_t  kind;
    logic [1:0] code;
    logic [7:0] sym;
  } cmd_t;

  // one result beat
  typedef struct packed {
    logic       has_symbol;
    logic [7:0] symbol;
    logic       last;
    logic [1:0] error_code;
  } res_t;

  // character emitted for a stacked operator code
  function automatic logic [7:0] code_char(input logic [1:0] code);
    logic [7:0] ch;
    unique case (code)
      OP_LPAREN: ch = CH_LPAREN;
      OP_STAR:   ch = CH_STAR;
      OP_CAT:    ch = CH_CAT;
      default:   ch = CH_ALT;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ritp_fifo.sv -----
// ritp_fifo: small synchronous queue of registers, used between the parts
// no package dependencies
`default_nettype none

module ritp_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [DATA_W-1:0] wr_data,
  output logic                   full,
  input  wire logic              rd_en,
  output logic [DATA_W-1:0]      rd_data,
  output logic                   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ritp_front.sv -----
// ritp_front: accepts input beats and classifies each byte into a command
// depends on ritp_pkg
`default_nettype none

module ritp_front
  import ritp_pkg::*;
(
  input  wire logic       in_push,
  input  wire logic       q_full,
  input  wire logic       in_action,
  input  wire logic [7:0] in_symbol,
  output logic            cmd_wr,
  output cmd_t            cmd
);

  logic keep;

  function automatic logic is_alnum(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  // classify, bytes of no meaning are dropped here
  always_comb begin
    keep      = 1'b1;
    cmd.kind  = CMD_OPERAND;
    cmd.code  = OP_LPAREN;
    cmd.sym   = in_symbol;
    priority if (in_action == ACT_FLUSH) begin
      cmd.kind = CMD_FLUSH;
    end else if (is_alnum(in_symbol)) begin
      cmd.kind = CMD_OPERAND;
    end else if (in_symbol == CH_STAR) begin
      cmd.kind = CMD_OPER;
      cmd.code = OP_STAR;
    end else if (in_symbol == CH_CAT) begin
      cmd.kind = CMD_OPER;
      cmd.code = OP_CAT;
    end else if (in_symbol == CH_ALT) begin
      cmd.kind = CMD_OPER;
      cmd.code = OP_ALT;
    end else if (in_symbol == CH_LPAREN) begin
      cmd.kind = CMD_LPAREN;
    end else if (in_symbol == CH_RPAREN) begin
      cmd.kind = CMD_RPAREN;
    end else begin
      keep = 1'b0;
    end
  end

  assign cmd_wr = in_push && !q_full && keep;

endmodule

`default_nettype wire

// ----- rtl/ritp_back.sv -----
// ritp_back: operator stack engine, one stack action
// per cycle, held by queue stalls; depends on ritp_pkg
`default_nettype none

module ritp_back
  import ritp_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cmd_t cmd,
  input  wire logic cmd_empty,
  output logic      cmd_pop,
  input  wire logic res_full,
  output logic      res_wr,
  output res_t      res
);

  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  logic [1:0]       stack_r [STACK_DEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [1:0]       err_r, err_nxt;
  logic [CNT_W-1:0] count_dec;
  logic [1:0]       top_code;
  logic             stk_empty, stk_full;
  logic             push_en;
  logic [1:0]       push_code;

  assign count_dec = count_r - 1'b1;
  assign top_code  = stack_r[count_dec[IDX_W-1:0]];
  assign stk_empty = (count_r == '0);
  assign stk_full  = (count_r == CNT_W'(STACK_DEPTH));

  // one step on the head command
  always_comb begin
    count_nxt = count_r;
    err_nxt   = err_r;
    cmd_pop   = 1'b0;
    res_wr    = 1'b0;
    res       = '0;
    push_en   = 1'b0;
    push_code = cmd.code;
    if (!cmd_empty) begin
      unique case (cmd.kind)
        CMD_OPERAND: begin
          if (!res_full) begin
            res_wr         = 1'b1;
            res.has_symbol = 1'b1;
            res.symbol     = cmd.sym;
            cmd_pop        = 1'b1;
          end
        end
        CMD_OPER: begin
          if (!stk_empty && top_code != OP_LPAREN && top_code <= cmd.code) begin
            // pop an operator that binds at least as tightly
            if (!res_full) begin
              res_wr         = 1'b1;
              res.has_symbol = 1'b1;
              res.symbol     = code_char(top_code);
              count_nxt      = count_dec;
            end
          end else begin
            cmd_pop = 1'b1;
            if (stk_full) begin
              if (err_r == ERR_NONE) err_nxt = ERR_OVERFLOW;
            end else begin
              push_en = 1'b1;
            end
          end
        end
        CMD_LPAREN: begin
          cmd_pop   = 1'b1;
          push_code = OP_LPAREN;
          if (stk_full) begin
            if (err_r == ERR_NONE) err_nxt = ERR_OVERFLOW;
          end else begin
            push_en = 1'b1;
          end
        end
        CMD_RPAREN: begin
          if (stk_empty) begin
            // no matching open parenthesis
            cmd_pop = 1'b1;
            if (err_r == ERR_NONE) err_nxt = ERR_PAREN;
          end else if (top_code == OP_LPAREN) begin
            cmd_pop   = 1'b1;
            count_nxt = count_dec;
          end else if (!res_full) begin
            res_wr         = 1'b1;
            res.has_symbol = 1'b1;
            res.symbol     = code_char(top_code);
            count_nxt      = count_dec;
          end
        end
        CMD_FLUSH: begin
          if (!stk_empty) begin
            if (top_code == OP_LPAREN) begin
              // unclosed parenthesis
              count_nxt = count_dec;
              if (err_r == ERR_NONE) err_nxt = ERR_PAREN;
            end else if (!res_full) begin
              res_wr         = 1'b1;
              res.has_symbol = 1'b1;
              res.symbol     = code_char(top_code);
              count_nxt      = count_dec;
            end
          end else if (!res_full) begin
            // closing beat with the sticky error
            res_wr         = 1'b1;
            res.last       = 1'b1;
            res.error_code = err_r;
            count_nxt      = '0;
            err_nxt        = ERR_NONE;
            cmd_pop        = 1'b1;
          end
        end
        default: begin
          cmd_pop = 1'b1;
        end
      endcase
    end
    if (push_en) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      err_r   <= ERR_NONE;
    end else begin
      count_r <= count_nxt;
      err_r   <= err_nxt;
    end
  end

  // stack entries, no reset
  always_ff @(posedge clk) begin
    if (push_en) begin
      stack_r[count_r[IDX_W-1:0]] <= push_code;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/regex_infix_to_postfix.sv -----
// a result beat passes the command queue, the stack engine and the result queue
// before it shows on the out_ ports; the stack engine does one push or pop a
// cycle unless an empty command queue or, for a beat it must emit, a full result
// queue holds it, and a flush pops every stacked entry before its closing beat
// reset: synchronous, active low; clears both queues, stack count and error
`default_nettype none

module regex_infix_to_postfix
  import ritp_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic       in_action,
  input  wire logic [7:0] in_symbol,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic            out_has_symbol,
  output logic [7:0]      out_symbol,
  output logic            out_last,
  output logic [1:0]      out_error_code
);

  cmd_t cmd_in, cmd_head;
  logic cmd_wr, cmd_pop, cmd_empty;
  res_t res_in, res_head;
  logic res_wr, res_full;

  // classify incoming beats
  ritp_front u_front (
    .in_push   (in_push),
    .q_full    (in_full),
    .in_action (in_action),
    .in_symbol (in_symbol),
    .cmd_wr    (cmd_wr),
    .cmd       (cmd_in)
  );

  // command queue between front and back
  ritp_fifo #(
    .DATA_W ($bits(cmd_t)),
    .DEPTH  (CMDQ_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_wr),
    .wr_data (cmd_in),
    .full    (in_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_head),
    .empty   (cmd_empty)
  );

  // stack engine
  ritp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_wr    (res_wr),
    .res       (res_in)
  );

  // result queue
  ritp_fifo #(
    .DATA_W ($bits(res_t)),
    .DEPTH  (RESQ_DEPTH)
  ) u_resq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_wr),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (out_pop),
    .rd_data (res_head),
    .empty   (out_empty)
  );

  assign out_has_symbol = res_head.has_symbol;
  assign out_symbol     = res_head.symbol;
  assign out_last       = res_head.last;
  assign out_error_code = res_head.error_code;

endmodule

`default_nettype wire

// ----- rtl/ritp_checker.sv -----
// ritp_checker: port-level assertions for regex_infix_to_postfix, bound to it
// depends on ritp_pkg
`default_nettype none

module ritp_checker
  import ritp_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_empty,
  input wire logic       out_pop,
  input wire logic       out_has_symbol,
  input wire logic [7:0] out_symbol,
  input wire logic       out_last,
  input wire logic [1:0] out_error_code
);

  // reset empties the result side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // a closing beat carries no symbol
  a_last_no_sym: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_last) |-> (!out_has_symbol && out_symbol == 8'h00))
    else $error("closing beat carries a symbol");

  // a symbol beat is never the closing one and reports no error
  a_sym_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_has_symbol) |-> (!out_last && out_error_code == ERR_NONE))
    else $error("symbol beat flagged last or error");

  // every beat is either a symbol or the closing beat, with a known error code
  a_beat_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ((out_has_symbol || out_last) &&
                    (out_error_code == ERR_NONE || out_error_code == ERR_PAREN ||
                     out_error_code == ERR_OVERFLOW)))
    else $error("malformed result beat");

  // a waiting beat holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_symbol) &&
                                  $stable(out_last)))
    else $error("waiting result beat changed");

endmodule

bind regex_infix_to_postfix ritp_checker u_ritp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_empty      (out_empty),
  .out_pop        (out_pop),
  .out_has_symbol (out_has_symbol),
  .out_symbol     (out_symbol),
  .out_last       (out_last),
  .out_error_code (out_error_code)
);

`default_nettype wire
